### src/rpp_pkg.sv
package rpp_pkg;

	localparam int COORD_WIDTH_DEF = 20;
	localparam int COEF_WIDTH_DEF  = 16;
	localparam int GUARD_BITS      = 2;
	localparam int NUM_AXES        = 3;

	// configuration register map
	localparam int CFG_INDEX_W = 3;
	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_ROW_0  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_ROW_1  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_FIRST_ROW_2  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SECOND_ROW_0 = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SECOND_ROW_1 = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SECOND_ROW_2 = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_PIVOT        = 3'd6;

	// width of the config data word: wide enough for a matrix row or the pivot
	function automatic int cfg_data_width(input int coord_w, input int coef_w);
		return (3 * coord_w > 3 * coef_w) ? 3 * coord_w : 3 * coef_w;
	endfunction

	// enables for the two register stages of one matrix unit
	typedef struct packed {
		logic mul_en;
		logic sum_en;
	} stage_ctl_t;

endpackage

### src/rpp_mat3.sv
module rpp_mat3 #(
	parameter int IN_W   = 21,
	parameter int COEF_W = 16,
	parameter int SHIFT  = 12,
	parameter int OUT_W  = 28
) (
	input  logic                     clk,
	input  rpp_pkg::stage_ctl_t      ctl,
	input  logic signed [IN_W-1:0]   vec  [rpp_pkg::NUM_AXES],
	input  logic [3*COEF_W-1:0]      rows [rpp_pkg::NUM_AXES],
	output logic signed [OUT_W-1:0]  res  [rpp_pkg::NUM_AXES]
);
	import rpp_pkg::*;

	localparam int PROD_W = IN_W + COEF_W;
	localparam int SUM_W  = PROD_W + 3;
	localparam logic signed [SUM_W-1:0] Half = SUM_W'(1) << (SHIFT - 1);

	logic signed [COEF_W-1:0] coef    [NUM_AXES][NUM_AXES];
	logic signed [PROD_W-1:0] prod_s1 [NUM_AXES][NUM_AXES];
	logic signed [SUM_W-1:0]  acc     [NUM_AXES];
	logic signed [OUT_W-1:0]  res_s2  [NUM_AXES];

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			for (int j = 0; j < NUM_AXES; j++) begin
				coef[i][j] = signed'(rows[i][j*COEF_W +: COEF_W]);
			end
		end
	end

	// one multiplier per matrix entry
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				for (int j = 0; j < NUM_AXES; j++) begin
					prod_s1[i][j] <= PROD_W'(vec[j]) * PROD_W'(coef[i][j]);
				end
			end
		end
	end

	// add half an LSB, then floor
	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			acc[i] = SUM_W'(prod_s1[i][0]) + SUM_W'(prod_s1[i][1])
				+ SUM_W'(prod_s1[i][2]) + Half;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.sum_en) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				res_s2[i] <= signed'(acc[i][SHIFT +: OUT_W]);
			end
		end
	end

	assign res = res_s2;

endmodule

### src/point_rotate_about_pivot_unit.sv
// Rotates a stream of 3D points (signed Q12.8) about a programmable pivot:
// subtract the pivot, multiply by the first 3x3 matrix, then by the second,
// add the pivot back and saturate each coordinate to COORD_WIDTH bits, with
// overflow set when any coordinate clipped. Matrix entries are signed Q2.14,
// three to a row register with column 0 in the low bits; the pivot register
// holds x, y, z with x lowest. Each matrix product is rounded to nearest with
// ties toward plus infinity; the vector between the two matrices carries two
// extra fraction bits and is never clipped. The datapath is a six-stage
// pipeline (pivot subtract, first-matrix multiply, first-matrix sum,
// second-matrix multiply, second-matrix sum, pivot add and clip), and one
// point is accepted every cycle while the output side keeps up; each matrix
// uses nine multipliers in parallel. A stall at the output backs up only
// through the occupied stages, so bubbles are squeezed out. Configuration
// writes take effect at once (cfg_ready is always high) and must only be
// issued while no point is in flight; indexes beyond the pivot register are
// dropped.
module point_rotate_about_pivot_unit #(
	parameter int COORD_WIDTH = rpp_pkg::COORD_WIDTH_DEF,
	parameter int COEF_WIDTH  = rpp_pkg::COEF_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rpp_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [rpp_pkg::cfg_data_width(COORD_WIDTH, COEF_WIDTH)-1:0] cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [COORD_WIDTH-1:0]         point_x,
	input  logic signed [COORD_WIDTH-1:0]         point_y,
	input  logic signed [COORD_WIDTH-1:0]         point_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [COORD_WIDTH-1:0]         out_x,
	output logic signed [COORD_WIDTH-1:0]         out_y,
	output logic signed [COORD_WIDTH-1:0]         out_z,
	output logic                                  overflow
);
	import rpp_pkg::*;

	localparam int ROW_W   = 3 * COEF_WIDTH;
	localparam int PIV_W   = 3 * COORD_WIDTH;
	localparam int DIFF_W  = COORD_WIDTH + 1;
	// widths after each rounded matrix product
	localparam int MID_W   = DIFF_W + COEF_WIDTH + 3 - (COEF_WIDTH - 2 - GUARD_BITS);
	localparam int FIN_W   = MID_W + COEF_WIDTH + 3 - (COEF_WIDTH - 2 + GUARD_BITS);
	localparam int TOT_W   = FIN_W + 1;
	localparam int HI_W    = TOT_W - COORD_WIDTH + 1;
	// the z pivot field reads as zero when it starts at bit 64 or above
	localparam bit PivZDrop = (2 * COORD_WIDTH >= 64);

	// identity rows: one in Q2.14 on the diagonal
	localparam logic [ROW_W-1:0] RowReset0 = ROW_W'(1) << (COEF_WIDTH - 2);
	localparam logic [ROW_W-1:0] RowReset1 = ROW_W'(1) << (2 * COEF_WIDTH - 2);
	localparam logic [ROW_W-1:0] RowReset2 = ROW_W'(1) << (3 * COEF_WIDTH - 2);

	localparam logic signed [COORD_WIDTH-1:0] MaxV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] MinV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	// ---------------------------------------------------------------- config
	logic [ROW_W-1:0] first_q  [NUM_AXES];
	logic [ROW_W-1:0] second_q [NUM_AXES];
	logic [PIV_W-1:0] pivot_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q[0]  <= RowReset0;
			first_q[1]  <= RowReset1;
			first_q[2]  <= RowReset2;
			second_q[0] <= RowReset0;
			second_q[1] <= RowReset1;
			second_q[2] <= RowReset2;
			pivot_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIRST_ROW_0:  first_q[0]  <= cfg_data[ROW_W-1:0];
				REG_FIRST_ROW_1:  first_q[1]  <= cfg_data[ROW_W-1:0];
				REG_FIRST_ROW_2:  first_q[2]  <= cfg_data[ROW_W-1:0];
				REG_SECOND_ROW_0: second_q[0] <= cfg_data[ROW_W-1:0];
				REG_SECOND_ROW_1: second_q[1] <= cfg_data[ROW_W-1:0];
				REG_SECOND_ROW_2: second_q[2] <= cfg_data[ROW_W-1:0];
				REG_PIVOT:        pivot_q     <= cfg_data[PIV_W-1:0];
				default: ; // drop writes to unmapped indexes
			endcase
		end
	end

	// pivot fields, x lowest
	logic signed [COORD_WIDTH-1:0] piv [NUM_AXES];

	always_comb begin
		piv[0] = signed'(pivot_q[0 +: COORD_WIDTH]);
		piv[1] = signed'(pivot_q[COORD_WIDTH +: COORD_WIDTH]);
		piv[2] = PivZDrop ? '0 : signed'(pivot_q[2*COORD_WIDTH +: COORD_WIDTH]);
	end

	// -------------------------------------------------------- flow control
	// A stage advances when it is empty or the next stage advances.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || out_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// ------------------------------------------- stage 1: subtract the pivot
	logic signed [COORD_WIDTH-1:0] pt   [NUM_AXES];
	logic signed [DIFF_W-1:0]      diff_s1 [NUM_AXES];

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < NUM_AXES; i++) begin
				diff_s1[i] <= DIFF_W'(pt[i]) - DIFF_W'(piv[i]);
			end
		end
	end

	// ------------------------------------- stages 2-3: first matrix, Q.10
	stage_ctl_t              ctl_a, ctl_b;
	logic signed [MID_W-1:0] mid [NUM_AXES];
	logic signed [FIN_W-1:0] fin [NUM_AXES];

	assign ctl_a = '{mul_en: en2, sum_en: en3};
	assign ctl_b = '{mul_en: en4, sum_en: en5};

	rpp_mat3 #(
		.IN_W  (DIFF_W),
		.COEF_W(COEF_WIDTH),
		.SHIFT (COEF_WIDTH - 2 - GUARD_BITS),
		.OUT_W (MID_W)
	) u_first (
		.clk (clk),
		.ctl (ctl_a),
		.vec (diff_s1),
		.rows(first_q),
		.res (mid)
	);

	// ---------------------------------- stages 4-5: second matrix, Q.8
	rpp_mat3 #(
		.IN_W  (MID_W),
		.COEF_W(COEF_WIDTH),
		.SHIFT (COEF_WIDTH - 2 + GUARD_BITS),
		.OUT_W (FIN_W)
	) u_second (
		.clk (clk),
		.ctl (ctl_b),
		.vec (mid),
		.rows(second_q),
		.res (fin)
	);

	// ------------------------------ stage 6: add the pivot back and clip
	logic signed [TOT_W-1:0]       tot  [NUM_AXES];
	logic [HI_W-1:0]               hi   [NUM_AXES];
	logic signed [COORD_WIDTH-1:0] clip [NUM_AXES];
	logic [NUM_AXES-1:0]           sat;
	logic signed [COORD_WIDTH-1:0] res_s6 [NUM_AXES];
	logic                          ovf_s6;

	always_comb begin
		for (int i = 0; i < NUM_AXES; i++) begin
			tot[i] = TOT_W'(fin[i]) + TOT_W'(piv[i]);
			// in range when every bit above the result's sign matches it
			hi[i]  = tot[i][TOT_W-1:COORD_WIDTH-1];
			sat[i] = !((&hi[i]) || !(|hi[i]));
			if (!sat[i]) begin
				clip[i] = signed'(tot[i][COORD_WIDTH-1:0]);
			end else if (tot[i][TOT_W-1]) begin
				clip[i] = MinV;
			end else begin
				clip[i] = MaxV;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			res_s6 <= clip;
			ovf_s6 <= |sat;
		end
	end

	assign out_valid = v_s6;
	assign out_x     = res_s6[0];
	assign out_y     = res_s6[1];
	assign out_z     = res_s6[2];
	assign overflow  = ovf_s6;

endmodule

### src/rpp_checker.sv
module rpp_checker #(
	parameter int COORD_WIDTH = rpp_pkg::COORD_WIDTH_DEF
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [COORD_WIDTH-1:0]         out_x,
	input logic signed [COORD_WIDTH-1:0]         out_y,
	input logic signed [COORD_WIDTH-1:0]         out_z,
	input logic                                  overflow
);

	localparam int Depth = 6;
	localparam logic signed [COORD_WIDTH-1:0] MaxV = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] MinV = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	logic [3:0] pending_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 4'(in_acc) - 4'(out_acc);
		end
	end

	// a held word keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_z) && $stable(overflow))
		else $error("output word changed while stalled");

	// no word appears without a point behind it
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 4'd0)
		else $error("output word without a pending point");

	// never more points in flight than pipeline stages
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'(Depth))
		else $error("more points in flight than stages");

	// an empty output stage lets the pipeline move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	// a flagged word has a clipped coordinate
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> out_x == MaxV || out_x == MinV || out_y == MaxV
			|| out_y == MinV || out_z == MaxV || out_z == MinV)
		else $error("overflow without a clipped coordinate");

endmodule

bind point_rotate_about_pivot_unit rpp_checker #(
	.COORD_WIDTH(COORD_WIDTH)
) u_rpp_checker (.*);
